// ===== hw/rtl/lmc_pkg.sv =====
package lmc_pkg;

	localparam int PANEL_WIDTH_DEF  = 32;
	localparam int PANEL_HEIGHT_DEF = 8;

	localparam int FONT_FIRST  = 32;
	localparam int FONT_CHARS  = 96;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;

	localparam logic signed [11:0] CURSOR_MAX = 12'sd2047;

	typedef enum logic [1:0] {
		CMD_FILL  = 2'd0,
		CMD_BLEND = 2'd1,
		CMD_CHAR  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// one glyph, element [4] is the leftmost column, bit r lights row r
	typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

	localparam glyph_t FONT_ROM [FONT_CHARS] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036363600, 40'h0056360000,
		40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
		40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
		40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
	};

endpackage

// ===== hw/rtl/lmc_ram.sv =====
module lmc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lmc_blend.sv =====
module lmc_blend (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] src,
	input  logic [7:0] dst,
	input  logic [7:0] alpha,
	output logic [7:0] res
);

	logic [15:0] prod_s1;
	logic [7:0]  src_s1;
	logic [16:0] div_sum;
	logic [7:0]  quot;
	logic [8:0]  total;

	// one channel per enable, product registered before the divide
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (8'd255 - alpha) * dst;
			src_s1  <= src;
		end
	end

	// exact floor divide by 255 for a product of at most 255*255
	always_comb begin
		div_sum = 17'(prod_s1) + 17'd1 + 17'(prod_s1[15:8]);
		quot    = div_sum[15:8];
		total   = 9'(src_s1) + 9'(quot);
		res     = total[8] ? 8'hFF : total[7:0];
	end

endmodule

// ===== hw/rtl/led_matrix_text_image_compositor.sv =====
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_ready | cmd, pos_x, pos_y, char_code, src_*, text_start,
//         |           |                     | skip_count, span_width
// out     | out       | out_valid/out_ready | pix_red, pix_green, pix_blue, in_bounds
// cfg     | in        | cfg_we              | cfg_wdata (background color)
//
// one request at a time; in_ready is low until the sequencer is back in idle
// fill: one frame store write per cycle, PANEL_WIDTH*PANEL_HEIGHT writes in all
// pixel blend on panel: read, then the shared multiplier does one channel a cycle, then the write
// character: walks the glyph column by column and row by row, read, blend and write for each lit pixel on panel
// read: frame store read, then the response step waits while the output register is still full
// async reset clears control and text state; the frame store is not cleared
module led_matrix_text_image_compositor
	import lmc_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [10:0] pos_x,
	input  logic signed [10:0] pos_y,
	input  logic [7:0]         char_code,
	input  logic [7:0]         src_red,
	input  logic [7:0]         src_green,
	input  logic [7:0]         src_blue,
	input  logic [7:0]         src_alpha,
	input  logic               text_start,
	input  logic signed [12:0] skip_count,
	input  logic [9:0]         span_width,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pix_red,
	output logic [7:0]         pix_green,
	output logic [7:0]         pix_blue,
	output logic               in_bounds
);

	localparam int NPIX = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int AW   = $clog2(NPIX);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_FILL = 8'b0000_0010,
		S_COL  = 8'b0000_0100,
		S_ROW  = 8'b0000_1000,
		S_ADV  = 8'b0001_0000,
		S_RD   = 8'b0010_0000,
		S_BL   = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

	// control state
	state_t            state_q;
	cmd_t              cmd_q;
	logic [AW-1:0]     fill_q;
	logic [2:0]        col_q;
	logic [2:0]        row_q;
	logic [1:0]        chan_q;
	logic              read_ok_q;
	logic              out_valid_q;
	logic [23:0]       bg_q;

	// text run state
	logic signed [11:0] cursor_q;
	logic signed [11:0] end_q;
	logic [11:0]        skip_q;
	logic               stopped_q;
	logic               unlim_q;

	// request payload, no reset
	logic [23:0]        src_q;
	logic [7:0]         alpha_q;
	logic signed [10:0] py_q;
	glyph_t             glyph_q;
	logic [AW-1:0]      addr_q;
	logic [15:0]        res_q;
	logic [23:0]        pix_q;
	logic               in_bounds_q;

	// frame store and blend unit wiring
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [23:0]        ram_wdata;
	logic               ram_re;
	logic [23:0]        ram_rdata;
	logic               bl_en;
	logic [7:0]         bl_src;
	logic [7:0]         bl_dst;
	logic [7:0]         bl_res;

	logic               accept;
	logic signed [11:0] px12;
	logic signed [11:0] py12;
	logic               in_on_panel;
	logic [AW-1:0]      in_addr;
	logic signed [13:0] cur_wide;
	logic signed [11:0] cur_load;
	logic signed [11:0] end_load;
	logic [11:0]        skip_load;
	logic               code_ok;
	logic               stop_eff;
	logic [6:0]         glyph_idx;
	logic [7:0]         col_byte;
	logic signed [11:0] row_y;
	logic               row_on_panel;
	logic [AW-1:0]      row_addr;
	logic signed [11:0] cur_next;
	logic               resp_load;

	function automatic logic on_panel(logic signed [11:0] x, logic signed [11:0] y);
		return !x[11] && !y[11] && ($unsigned(x) < 12'(PANEL_WIDTH)) &&
			($unsigned(y) < 12'(PANEL_HEIGHT));
	endfunction

	function automatic logic [AW-1:0] pix_addr(logic signed [11:0] x,
		logic signed [11:0] y);
		return AW'($unsigned(y)) * AW'(PANEL_WIDTH) + AW'($unsigned(x));
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// request decode
	always_comb begin
		px12        = {pos_x[10], pos_x};
		py12        = {pos_y[10], pos_y};
		in_on_panel = on_panel(px12, py12);
		in_addr     = pix_addr(px12, py12);
		// negative skip moves the origin right, positive skip is consumed column by column
		if (skip_count[12]) begin
			cur_wide  = {{3{pos_x[10]}}, pos_x} - {skip_count[12], skip_count};
			skip_load = '0;
		end else begin
			cur_wide  = {{3{pos_x[10]}}, pos_x};
			skip_load = skip_count[11:0];
		end
		cur_load  = (cur_wide > 14'(CURSOR_MAX)) ? CURSOR_MAX : cur_wide[11:0];
		end_load  = px12 + $signed({2'b00, span_width});
		code_ok   = !char_code[7] && (char_code >= 8'(FONT_FIRST));
		stop_eff  = text_start ? 1'b0 : stopped_q;
		glyph_idx = 7'(char_code - 8'(FONT_FIRST));
	end

	// character walk
	always_comb begin
		col_byte     = glyph_q[3'(GLYPH_COLS - 1) - col_q];
		row_y        = $signed({py_q[10], py_q}) + $signed({9'b0, row_q});
		row_on_panel = on_panel(cursor_q, row_y);
		row_addr     = pix_addr(cursor_q, row_y);
		cur_next     = (cursor_q == CURSOR_MAX) ? cursor_q : cursor_q + 12'sd1;
		resp_load    = (state_q == S_RESP) && (!out_valid_q || out_ready);
	end

	// shared blend unit, one channel per cycle
	always_comb begin
		bl_en = (state_q == S_BL) && (chan_q != 2'd3);
		case (chan_q)
			2'd0: begin
				bl_src = src_q[7:0];
				bl_dst = ram_rdata[7:0];
			end
			2'd1: begin
				bl_src = src_q[15:8];
				bl_dst = ram_rdata[15:8];
			end
			default: begin
				bl_src = src_q[23:16];
				bl_dst = ram_rdata[23:16];
			end
		endcase
	end

	// frame store ports
	always_comb begin
		ram_re = (state_q == S_RD);
		if (state_q == S_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q;
			ram_wdata = bg_q;
		end else begin
			ram_we    = (state_q == S_BL) && (chan_q == 2'd3);
			ram_waddr = addr_q;
			ram_wdata = {bl_res, res_q};
		end
	end

	// sequencer and text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_FILL;
			fill_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			chan_q      <= '0;
			read_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			bg_q        <= '0;
			cursor_q    <= '0;
			end_q       <= '0;
			skip_q      <= '0;
			stopped_q   <= 1'b0;
			unlim_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				bg_q <= cfg_wdata;
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_t'(cmd);
						unique case (cmd_t'(cmd))
							CMD_FILL: begin
								fill_q  <= '0;
								state_q <= S_FILL;
							end
							CMD_BLEND: begin
								if (in_on_panel) begin
									state_q <= S_RD;
								end
							end
							CMD_READ: begin
								read_ok_q <= in_on_panel;
								state_q   <= in_on_panel ? S_RD : S_RESP;
							end
							CMD_CHAR: begin
								if (text_start) begin
									cursor_q  <= cur_load;
									end_q     <= end_load;
									skip_q    <= skip_load;
									stopped_q <= 1'b0;
									unlim_q   <= (span_width == '0);
								end
								if (!stop_eff && code_ok) begin
									col_q   <= '0;
									state_q <= S_COL;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == AW'(NPIX - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_COL: begin
					if (col_q == 3'(GLYPH_COLS)) begin
						// blank column after the glyph
						if (skip_q == '0) begin
							cursor_q <= cur_next;
						end else begin
							skip_q <= skip_q - 1'b1;
						end
						state_q <= S_IDLE;
					end else if (skip_q != '0) begin
						skip_q <= skip_q - 1'b1;
						col_q  <= col_q + 1'b1;
					end else begin
						row_q   <= '0;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (row_q == 3'(GLYPH_ROWS)) begin
						state_q <= S_ADV;
					end else if (col_byte[row_q] && row_on_panel) begin
						state_q <= S_RD;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_ADV: begin
					cursor_q <= cur_next;
					if (!unlim_q && (cur_next >= end_q)) begin
						stopped_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_COL;
					end
				end
				S_RD: begin
					chan_q  <= '0;
					state_q <= (cmd_q == CMD_READ) ? S_RESP : S_BL;
				end
				S_BL: begin
					chan_q <= chan_q + 1'b1;
					if (chan_q == 2'd3) begin
						if (cmd_q == CMD_CHAR) begin
							row_q   <= row_q + 1'b1;
							state_q <= S_ROW;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			src_q   <= {src_blue, src_green, src_red};
			alpha_q <= src_alpha;
			py_q    <= pos_y;
			addr_q  <= in_addr;
			glyph_q <= FONT_ROM[glyph_idx];
		end else if ((state_q == S_ROW) && (row_q != 3'(GLYPH_ROWS))) begin
			addr_q <= row_addr;
		end
		if (state_q == S_BL) begin
			if (chan_q == 2'd1) begin
				res_q[7:0] <= bl_res;
			end
			if (chan_q == 2'd2) begin
				res_q[15:8] <= bl_res;
			end
		end
		if (resp_load) begin
			pix_q       <= read_ok_q ? ram_rdata : '0;
			in_bounds_q <= read_ok_q;
		end
	end

	lmc_ram #(
		.WIDTH(24),
		.DEPTH(NPIX)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	lmc_blend u_blend (
		.clk  (clk),
		.en   (bl_en),
		.src  (bl_src),
		.dst  (bl_dst),
		.alpha(alpha_q),
		.res  (bl_res)
	);

	assign out_valid = out_valid_q;
	assign pix_red   = pix_q[7:0];
	assign pix_green = pix_q[15:8];
	assign pix_blue  = pix_q[23:16];
	assign in_bounds = in_bounds_q;

endmodule

// ===== hw/rtl/lmc_checker.sv =====
module lmc_checker
	import lmc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pix_red,
	input logic [7:0] pix_green,
	input logic [7:0] pix_blue,
	input logic       in_bounds
);

	// a held result keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pix_red) &&
			$stable(pix_green) && $stable(pix_blue) && $stable(in_bounds))
		else $error("result changed while stalled");

	// off-panel read gives zero colors
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_bounds |-> pix_red == 8'd0 && pix_green == 8'd0 &&
			pix_blue == 8'd0)
		else $error("off-panel read with nonzero color");

	// fill and read requests take the block out of idle, so it is not ready right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_FILL || cmd == CMD_READ) |=> !in_ready)
		else $error("block ready right after fill or read request");

	// a new result comes only out of the busy response step
	a_resp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a read in flight");

endmodule

bind led_matrix_text_image_compositor lmc_checker u_lmc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

import lmc_pkg::*;

localparam int PANEL_W    = PANEL_WIDTH_DEF;
localparam int PANEL_H    = PANEL_HEIGHT_DEF;
localparam int CURSOR_TOP = 2047;

typedef struct {
	cmd_t               cmd;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic [7:0]         char_code;
	logic [7:0]         src_red;
	logic [7:0]         src_green;
	logic [7:0]         src_blue;
	logic [7:0]         src_alpha;
	logic               text_start;
	logic signed [12:0] skip_count;
	logic [9:0]         span_width;
} request_t;

typedef struct {
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       in_bounds;
} pixel_read_t;

// mirror of the frame buffer and text state, plus the reads still owed
class frame_tracker;
	logic [23:0] frame [PANEL_W*PANEL_H];
	logic [23:0] background;
	int          cursor;
	int          end_col;
	int          skip_left;
	bit          stopped;
	bit          unlimited;
	logic [39:0] font [96];
	pixel_read_t pending_reads [$];
	int          errors;

	function new();
		foreach (frame[i])
			frame[i] = '0;
		background = '0;
		cursor     = 0;
		end_col    = 0;
		skip_left  = 0;
		stopped    = 0;
		unlimited  = 1;
		errors     = 0;
		// leftmost column in the top byte, bit r of a column lights row r
		font = '{
			40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
			40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
			40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
			40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
			40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
			40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
			40'h3649494936, 40'h064949291E, 40'h0036363600, 40'h0056360000,
			40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
			40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
			40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
			40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
			40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
			40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
			40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
			40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
			40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
			40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
			40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
			40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
			40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
			40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
			40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
			40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
			40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
		};
	endfunction

	function void set_background(logic [23:0] color);
		background = color;
	endfunction

	function bit on_panel(int x, int y);
		return x >= 0 && x < PANEL_W && y >= 0 && y < PANEL_H;
	endfunction

	function void blend_at(int x, int y, logic [23:0] src, logic [7:0] alpha);
		logic [23:0] dst;
		logic [23:0] res;
		int          c;
		int          s;
		int          d;
		int          v;
		if (!on_panel(x, y))
			return;
		dst = frame[y*PANEL_W + x];
		for (c = 0; c < 3; c++) begin
			s = src[8*c +: 8];
			d = dst[8*c +: 8];
			v = s + (255 - int'(alpha)) * d / 255;
			res[8*c +: 8] = (v > 255) ? 8'hFF : 8'(v);
		end
		frame[y*PANEL_W + x] = res;
	endfunction

	function void step_cursor();
		if (cursor < CURSOR_TOP)
			cursor++;
	endfunction

	function void draw_char(request_t rq);
		int          px;
		int          py;
		int          code;
		int          skip;
		int          c;
		int          col_i;
		int          r;
		logic [7:0]  column;
		logic [23:0] src;
		px   = rq.pos_x;
		py   = rq.pos_y;
		code = rq.char_code;
		skip = rq.skip_count;
		src  = {rq.src_blue, rq.src_green, rq.src_red};
		if (rq.text_start) begin
			end_col   = px + int'(rq.span_width);
			unlimited = (rq.span_width == 0);
			stopped   = 0;
			if (skip < 0) begin
				c         = px - skip;
				skip_left = 0;
			end else begin
				c         = px;
				skip_left = skip;
			end
			cursor = (c > CURSOR_TOP) ? CURSOR_TOP : c;
		end
		if (stopped || code < 32 || code > 127)
			return;
		for (col_i = 0; col_i < 5; col_i++) begin
			if (skip_left == 0) begin
				column = font[code-32][39-8*col_i -: 8];
				for (r = 0; r < 7; r++)
					if (column[r])
						blend_at(cursor, py + r, src, rq.src_alpha);
				step_cursor();
				if (!unlimited && cursor >= end_col) begin
					stopped = 1;
					return;
				end
			end else begin
				skip_left--;
			end
		end
		// blank column after the glyph
		if (skip_left == 0)
			step_cursor();
		else
			skip_left--;
	endfunction

	function void note_request(request_t rq);
		pixel_read_t exp;
		case (rq.cmd)
			CMD_FILL: begin
				foreach (frame[i])
					frame[i] = background;
			end
			CMD_BLEND: begin
				blend_at(rq.pos_x, rq.pos_y, {rq.src_blue, rq.src_green, rq.src_red},
					rq.src_alpha);
			end
			CMD_CHAR: begin
				draw_char(rq);
			end
			CMD_READ: begin
				if (on_panel(rq.pos_x, rq.pos_y)) begin
					exp.red       = frame[rq.pos_y*PANEL_W + rq.pos_x][7:0];
					exp.green     = frame[rq.pos_y*PANEL_W + rq.pos_x][15:8];
					exp.blue      = frame[rq.pos_y*PANEL_W + rq.pos_x][23:16];
					exp.in_bounds = 1'b1;
				end else begin
					exp = '{8'h00, 8'h00, 8'h00, 1'b0};
				end
				pending_reads.push_back(exp);
			end
		endcase
	endfunction

	function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
		if (act !== exp) begin
			errors++;
			if (errors <= 40)
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
		end
	endfunction

	function void check_read(pixel_read_t got);
		pixel_read_t exp;
		if (pending_reads.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t unexpected read result: expected none, actual %h %h %h %b",
					$time, got.red, got.green, got.blue, got.in_bounds);
			return;
		end
		exp = pending_reads.pop_front();
		compare_field("pix_red", exp.red, got.red);
		compare_field("pix_green", exp.green, got.green);
		compare_field("pix_blue", exp.blue, got.blue);
		compare_field("in_bounds", exp.in_bounds, got.in_bounds);
	endfunction
endclass

module tb_top;

	// drain time for a fill or a character to finish
	localparam int DRAIN_CYCLES     = 400;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT      = 5_000_000;
	localparam int PHASE_ITEMS      = 420;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [23:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic [7:0]         char_code;
	logic [7:0]         src_red;
	logic [7:0]         src_green;
	logic [7:0]         src_blue;
	logic [7:0]         src_alpha;
	logic               text_start;
	logic signed [12:0] skip_count;
	logic [9:0]         span_width;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         pix_red;
	logic [7:0]         pix_green;
	logic [7:0]         pix_blue;
	logic               in_bounds;

	frame_tracker board;

	// idling knobs: gap_pct belongs to the sender, stall_pct to the receiver
	int   gap_pct = 0;
	int   stall_pct = 0;
	logic long_hold = 1'b0;

	// state of the text run being generated
	int          run_left = 0;
	logic [10:0] run_y;
	logic [31:0] run_rgba;

	always #5 clk = ~clk;

	led_matrix_text_image_compositor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.char_code  (char_code),
		.src_red    (src_red),
		.src_green  (src_green),
		.src_blue   (src_blue),
		.src_alpha  (src_alpha),
		.text_start (text_start),
		.skip_count (skip_count),
		.span_width (span_width),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pix_red    (pix_red),
		.pix_green  (pix_green),
		.pix_blue   (pix_blue),
		.in_bounds  (in_bounds)
	);

	// every field at full range, alpha biased toward opaque and additive
	function automatic request_t any_request();
		request_t rq;
		rq.cmd       = cmd_t'($urandom_range(3));
		rq.pos_x     = 11'($urandom);
		rq.pos_y     = 11'($urandom);
		rq.char_code = 8'($urandom);
		rq.src_red   = 8'($urandom);
		rq.src_green = 8'($urandom);
		rq.src_blue  = 8'($urandom);
		case ($urandom_range(7))
			0, 1:    rq.src_alpha = 8'hFF;
			2:       rq.src_alpha = 8'h00;
			default: rq.src_alpha = 8'($urandom);
		endcase
		rq.text_start = 1'($urandom);
		rq.skip_count = 13'($urandom);
		rq.span_width = 10'($urandom);
		return rq;
	endfunction

	// mostly on the panel or just off its edges, sometimes anywhere
	function automatic void aim_at_panel(ref request_t rq);
		if ($urandom_range(9) != 0) begin
			rq.pos_x = 11'(int'($urandom_range(PANEL_W + 5)) - 3);
			rq.pos_y = 11'(int'($urandom_range(PANEL_H + 5)) - 3);
		end
	endfunction

	// rgba packs red in the top byte, alpha in the bottom byte
	function automatic request_t pixel_op(cmd_t op, int x, int y, logic [31:0] rgba);
		request_t rq;
		rq = any_request();
		rq.cmd = op;
		rq.pos_x = 11'(x);
		rq.pos_y = 11'(y);
		{rq.src_red, rq.src_green, rq.src_blue, rq.src_alpha} = rgba;
		return rq;
	endfunction

	function automatic request_t text_op(int x, int y, int code, bit start, int skip,
		int span, logic [31:0] rgba);
		request_t rq;
		rq = pixel_op(CMD_CHAR, x, y, rgba);
		rq.char_code  = 8'(code);
		rq.text_start = start;
		rq.skip_count = 13'(skip);
		rq.span_width = 10'(span);
		return rq;
	endfunction

	// mostly well formed text runs between pixel traffic, some noise
	function automatic request_t random_request();
		request_t rq;
		int       pick;
		rq = any_request();
		if (run_left > 0) begin
			// next character of the current run
			run_left--;
			rq.cmd        = CMD_CHAR;
			rq.text_start = 1'b0;
			rq.pos_y      = run_y;
			if ($urandom_range(15) != 0)
				rq.char_code = 8'($urandom_range(127, 32));
			{rq.src_red, rq.src_green, rq.src_blue, rq.src_alpha} = run_rgba;
			return rq;
		end
		pick = $urandom_range(99);
		if (pick < 3) begin
			rq.cmd = CMD_FILL;
		end else if (pick < 28) begin
			rq.cmd = CMD_BLEND;
			aim_at_panel(rq);
		end else if (pick < 58) begin
			rq.cmd = CMD_READ;
			aim_at_panel(rq);
		end else if (pick < 88) begin
			// start of a run near the panel, short skips and spans
			rq.cmd        = CMD_CHAR;
			rq.text_start = 1'b1;
			rq.pos_x      = 11'(int'($urandom_range(50)) - 10);
			rq.pos_y      = 11'(int'($urandom_range(16)) - 7);
			if ($urandom_range(9) < 7)
				rq.skip_count = 13'(int'($urandom_range(28)) - 8);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: rq.span_width = '0;
				17, 18, 19:                   rq.span_width = 10'($urandom);
				default:                      rq.span_width = 10'($urandom_range(40, 1));
			endcase
			if ($urandom_range(15) != 0)
				rq.char_code = 8'($urandom_range(127, 32));
			run_left = $urandom_range(6, 1);
			run_y    = rq.pos_y;
			run_rgba = {rq.src_red, rq.src_green, rq.src_blue, rq.src_alpha};
		end else begin
			// noise: a character request with every field random
			rq.cmd = CMD_CHAR;
		end
		return rq;
	endfunction

	// offer one request, hold it until accepted, then record it
	task automatic send_request(input request_t rq);
		int gap;
		gap = 0;
		if ($urandom_range(99) < gap_pct)
			gap = ($urandom_range(15) == 0) ? $urandom_range(300, 1) : $urandom_range(8, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= rq.cmd;
		pos_x      <= rq.pos_x;
		pos_y      <= rq.pos_y;
		char_code  <= rq.char_code;
		src_red    <= rq.src_red;
		src_green  <= rq.src_green;
		src_blue   <= rq.src_blue;
		src_alpha  <= rq.src_alpha;
		text_start <= rq.text_start;
		skip_count <= rq.skip_count;
		span_width <= rq.span_width;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		board.note_request(rq);
	endtask

	task automatic write_background(input logic [23:0] color);
		cfg_we    <= 1'b1;
		cfg_wdata <= color;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_background(color);
	endtask

	// let every read come back, then give a fill or character time to finish
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic directed_requests();
		// fill first so no pixel is ever read before it has been written
		send_request(pixel_op(CMD_FILL, 0, 0, $urandom));
		// corners and just past every edge
		send_request(pixel_op(CMD_READ, 0, 0, $urandom));
		send_request(pixel_op(CMD_READ, PANEL_W - 1, PANEL_H - 1, $urandom));
		send_request(pixel_op(CMD_READ, -1, 0, $urandom));
		send_request(pixel_op(CMD_READ, PANEL_W, 0, $urandom));
		send_request(pixel_op(CMD_READ, 0, -1, $urandom));
		send_request(pixel_op(CMD_READ, 0, PANEL_H, $urandom));
		send_request(pixel_op(CMD_READ, -1024, 1023, $urandom));
		send_request(pixel_op(CMD_READ, 1023, -1024, $urandom));
		// opaque replace, then additive blend that saturates
		send_request(pixel_op(CMD_BLEND, 0, 0, 32'hFF0080FF));
		send_request(pixel_op(CMD_BLEND, 0, 0, 32'h80FF8000));
		send_request(pixel_op(CMD_BLEND, PANEL_W - 1, PANEL_H - 1, 32'h20406080));
		// clipped blend left of the panel
		send_request(pixel_op(CMD_BLEND, -1, 3, 32'hFFFFFFFF));
		send_request(pixel_op(CMD_READ, 0, 0, $urandom));
		send_request(pixel_op(CMD_READ, PANEL_W - 1, PANEL_H - 1, $urandom));
		// unlimited run, then a continuation character
		send_request(text_op(0, 0, 48, 1'b1, 0, 0, 32'hFFFFFFFF));
		send_request(text_op(0, 0, 65, 1'b0, 0, 0, 32'h10204080));
		// positive skip eats the first columns
		send_request(text_op(2, 1, 127, 1'b1, 3, 0, 32'h30303000));
		// negative skip shifts right, span ends the run inside the glyph
		send_request(text_op(10, -3, 33, 1'b1, -4, 6, 32'h00FF00FF));
		// stopped run draws nothing
		send_request(text_op(10, -3, 34, 1'b0, 0, 0, 32'hFF0000FF));
		// codes below and above the font, then a space
		send_request(text_op(20, 2, 31, 1'b1, 0, 0, 32'hFFFFFFFF));
		send_request(text_op(20, 2, 128, 1'b0, 0, 0, 32'hFFFFFFFF));
		send_request(text_op(20, 2, 32, 1'b0, 0, 0, 32'hFFFFFFFF));
		// field extremes, cursor saturation at the top column
		send_request(text_op(-1024, 1023, 255, 1'b1, 4095, 1023, 32'hFFFFFF80));
		send_request(text_op(1023, -1024, 90, 1'b1, -4096, 1, 32'hFFFFFFFF));
		send_request(pixel_op(CMD_READ, 2, 3, $urandom));
	endtask

	// receiver holds off for a long stretch while reads keep coming
	task automatic pressure_phase();
		request_t rq;
		int       n;
		gap_pct   = 0;
		stall_pct <= 0;
		long_hold <= 1'b1;
		for (n = 0; n < 40; n++) begin
			rq = any_request();
			rq.cmd = ($urandom_range(3) == 0) ? CMD_BLEND : CMD_READ;
			aim_at_panel(rq);
			send_request(rq);
		end
		long_hold <= 1'b0;
	endtask

	// receiver: check every accepted result, stall as the phase asks
	initial begin
		int hold_left;
		bit hold_armed;
		hold_left  = 0;
		hold_armed = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				board.check_read(pixel_read_t'{pix_red, pix_green, pix_blue, in_bounds});
			// long hold-off counted here, armed by the rising long_hold
			if (long_hold && !hold_armed)
				hold_left = LONG_HOLD_CYCLES;
			hold_armed = long_hold;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// main sequence
	initial begin
		int phase;
		int gap_by_phase [4];
		int stall_by_phase [4];
		int n;
		gap_by_phase   = '{0, 65, 0, 36};
		stall_by_phase = '{0, 0, 65, 36};
		board      = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		cmd        = CMD_FILL;
		pos_x      = '0;
		pos_y      = '0;
		char_code  = '0;
		src_red    = '0;
		src_green  = '0;
		src_blue   = '0;
		src_alpha  = '0;
		text_start = 1'b0;
		skip_count = '0;
		span_width = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_background(24'h000000);
		directed_requests();

		// random phases, each under its own background and idling mix
		for (phase = 0; phase < 4; phase++) begin
			drain();
			write_background((phase == 0) ? 24'hFFFFFF : 24'($urandom));
			gap_pct   = gap_by_phase[phase];
			stall_pct <= stall_by_phase[phase];
			run_left  = 0;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request());
		end

		drain();
		write_background(24'h7F00FF);
		pressure_phase();

		drain();
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lmc_pkg.sv
hw/rtl/lmc_ram.sv
hw/rtl/lmc_blend.sv
hw/rtl/led_matrix_text_image_compositor.sv
hw/rtl/lmc_checker.sv
bench/tb_top.sv
